@@ hw/rtl/bayer_nearest_neighbour_demosaic_core_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the nearest-neighbor demosaic core
// Concurrent assertion shorthands used by the checker file.
// ----------------------------------------------------------------------------
`ifndef BAYER_NEAREST_NEIGHBOUR_DEMOSAIC_CORE_ASSERT_SVH
`define BAYER_NEAREST_NEIGHBOUR_DEMOSAIC_CORE_ASSERT_SVH

// Clocked assertion, aborted while reset is high
`define BNND_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that is also checked during reset
`define BNND_ASSERT_RST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hw/rtl/bnnd_pkg.sv @@
// ----------------------------------------------------------------------------
// bnnd_pkg
// Types and constants of the nearest-neighbor RGGB demosaic core.
// ----------------------------------------------------------------------------
`default_nettype none

package bnnd_pkg;

  // Line store depth default (pixel pairs per row)
  localparam int MAX_LINE_PAIRS_DEF = 2048;

  // Row length register
  localparam int          LINE_PAIRS_W     = 12;
  localparam logic [11:0] LINE_PAIRS_RESET = 12'd2048;

  // Result queue between front and back
  localparam int QUEUE_DEPTH_DEF = 4;

  // Fixed field widths
  localparam int PIX_W = 8;
  localparam int QCOL_W = 11;

  // Input item: two packed 12-bit pixels, top bits only
  typedef struct packed {
    logic [PIX_W-1:0] byte_a;
    logic [PIX_W-1:0] byte_b;
    logic [PIX_W-1:0] byte_c;
  } in_item_t;

  // Result item: one color set per 2x2 quad
  typedef struct packed {
    logic [PIX_W-1:0]  red;
    logic [PIX_W-1:0]  green_upper;
    logic [PIX_W-1:0]  green_lower;
    logic [PIX_W-1:0]  blue;
    logic [QCOL_W-1:0] quad_column;
    logic              row_end;
  } out_item_t;

endpackage

`default_nettype wire

@@ hw/rtl/bnnd_front.sv @@
// ----------------------------------------------------------------------------
// bnnd_front
// Accepts pixel pairs, tracks row position, writes even rows into the line
// store and reads it back for odd rows, handing quad results to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module bnnd_front #(
  parameter int MAX_LINE_PAIRS = bnnd_pkg::MAX_LINE_PAIRS_DEF,
  parameter int QUEUE_DEPTH    = bnnd_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  // item side
  input  wire logic                               push,
  output logic                                    full,
  input  wire bnnd_pkg::in_item_t                 item,
  // row length register
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [bnnd_pkg::LINE_PAIRS_W-1:0]  cfg_line_pairs,
  // toward the queue
  output logic                                    q_push,
  output bnnd_pkg::out_item_t                     q_item,
  input  wire logic [$clog2(QUEUE_DEPTH+1)-1:0]   q_count
);

  localparam int COL_W = $clog2(MAX_LINE_PAIRS);
  localparam int EFF_W = $clog2(MAX_LINE_PAIRS + 1);
  localparam int CMP_W = ((EFF_W > bnnd_pkg::LINE_PAIRS_W) ? EFF_W : bnnd_pkg::LINE_PAIRS_W) + 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CMP_W-1:0] MAX_CMP = CMP_W'(MAX_LINE_PAIRS);
  localparam logic [CMP_W-1:0] ONE_CMP = CMP_W'(1);

  logic [bnnd_pkg::LINE_PAIRS_W-1:0] line_pairs;
  logic [COL_W-1:0]                  pair_column;
  logic                              odd_row;

  logic [CMP_W-1:0]                  lp_cmp;
  logic [CMP_W-1:0]                  eff_pairs;
  logic                              last;
  logic                              accept;
  logic [bnnd_pkg::PIX_W-1:0]        first_pix;
  logic [bnnd_pkg::PIX_W-1:0]        second_pix;

  // line store, first pixel in the high byte
  logic [2*bnnd_pkg::PIX_W-1:0]      line_store [MAX_LINE_PAIRS];
  logic [2*bnnd_pkg::PIX_W-1:0]      rd_data;

  // read stage
  logic                              s1_valid;
  logic [bnnd_pkg::PIX_W-1:0]        s1_green_lower;
  logic [bnnd_pkg::PIX_W-1:0]        s1_blue;
  logic [COL_W-1:0]                  s1_col;
  logic                              s1_last;

  // register writes are always taken
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_pairs <= bnnd_pkg::LINE_PAIRS_RESET;
    end else if (cfg_valid) begin
      line_pairs <= cfg_line_pairs;
    end
  end

  // effective row length: zero acts as one, clamp to the store depth
  always_comb begin
    lp_cmp = CMP_W'(line_pairs);
    if (lp_cmp == '0) begin
      eff_pairs = ONE_CMP;
    end else if (lp_cmp > MAX_CMP) begin
      eff_pairs = MAX_CMP;
    end else begin
      eff_pairs = lp_cmp;
    end
  end

  assign last = (CMP_W'(pair_column) + ONE_CMP) >= eff_pairs;

  // unpack top 8 bits of both pixels
  assign first_pix  = item.byte_a;
  assign second_pix = {item.byte_b[3:0], item.byte_c[7:4]};

  // room for the item in flight plus whatever the queue holds
  assign full   = (q_count + CNT_W'(s1_valid)) >= CNT_W'(QUEUE_DEPTH);
  assign accept = push && !full;

  // row position
  always_ff @(posedge clk) begin
    if (rst) begin
      pair_column <= '0;
      odd_row     <= 1'b0;
    end else if (accept) begin
      if (last) begin
        pair_column <= '0;
        odd_row     <= ~odd_row;
      end else begin
        pair_column <= pair_column + COL_W'(1);
      end
    end
  end

  // line store: even rows write, odd rows read
  always_ff @(posedge clk) begin
    if (accept && !odd_row) begin
      line_store[pair_column] <= {first_pix, second_pix};
    end
  end

  always_ff @(posedge clk) begin
    if (accept && odd_row) begin
      rd_data <= line_store[pair_column];
    end
  end

  // read stage control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept && odd_row;
    end
  end

  // read stage payload
  always_ff @(posedge clk) begin
    if (accept && odd_row) begin
      s1_green_lower <= first_pix;
      s1_blue        <= second_pix;
      s1_col         <= pair_column;
      s1_last        <= last;
    end
  end

  // quad result toward the queue
  always_comb begin
    q_push              = s1_valid;
    q_item.red          = rd_data[2*bnnd_pkg::PIX_W-1:bnnd_pkg::PIX_W];
    q_item.green_upper  = rd_data[bnnd_pkg::PIX_W-1:0];
    q_item.green_lower  = s1_green_lower;
    q_item.blue         = s1_blue;
    q_item.quad_column  = bnnd_pkg::QCOL_W'(s1_col);
    q_item.row_end      = s1_last;
  end

endmodule

`default_nettype wire

@@ hw/rtl/bnnd_queue.sv @@
// ----------------------------------------------------------------------------
// bnnd_queue
// Short result queue; its head drives the result ports until popped.
// ----------------------------------------------------------------------------
`default_nettype none

module bnnd_queue #(
  parameter int QUEUE_DEPTH = bnnd_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              q_push,
  input  wire bnnd_pkg::out_item_t               q_item,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0]       q_count,
  input  wire logic                              pop,
  output logic                                   empty,
  output bnnd_pkg::out_item_t                    result
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

  bnnd_pkg::out_item_t entries [QUEUE_DEPTH];
  logic [PTR_W-1:0]    wr_ptr;
  logic [PTR_W-1:0]    rd_ptr;
  logic [CNT_W-1:0]    count;
  logic                do_pop;

  assign empty   = (count == '0);
  assign do_pop  = pop && !empty;
  assign q_count = count;
  assign result  = entries[rd_ptr];

  // storage; the front never pushes into a full queue
  always_ff @(posedge clk) begin
    if (q_push) begin
      entries[wr_ptr] <= q_item;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (q_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (q_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !q_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/bayer_nearest_neighbour_demosaic_core.sv @@
// ----------------------------------------------------------------------------
// bayer_nearest_neighbour_demosaic_core
// Nearest-neighbor RGGB demosaic of a packed 12-bit pixel-pair stream.
// ----------------------------------------------------------------------------
//  channel  | handshake            | payload
//  ---------+----------------------+-------------------------------------
//  item     | push / full          | bnnd_pkg::in_item_t (3 packed bytes)
//  result   | pop / empty          | bnnd_pkg::out_item_t (one quad)
//  cfg      | cfg_valid / cfg_ready| cfg_line_pairs (12 bits)
//
//  One item per cycle sustained while full is low; the single line store
//  port (write on even rows, read on odd rows) takes one access per cycle.
//  A result is registered in the read stage, then written into the queue.
//  full rises once the read stage and the 4-entry queue together hold four.
//  Synchronous reset; the line store is not cleared, so no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module bayer_nearest_neighbour_demosaic_core #(
  parameter int MAX_LINE_PAIRS = bnnd_pkg::MAX_LINE_PAIRS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              push,
  output logic                                   full,
  input  wire bnnd_pkg::in_item_t                item,
  output logic                                   empty,
  input  wire logic                              pop,
  output bnnd_pkg::out_item_t                    result,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [bnnd_pkg::LINE_PAIRS_W-1:0] cfg_line_pairs
);

  localparam int QDEPTH = bnnd_pkg::QUEUE_DEPTH_DEF;

  logic                         q_push;
  bnnd_pkg::out_item_t          q_item;
  logic [$clog2(QDEPTH+1)-1:0]  q_count;

  // front: position tracking and line store
  bnnd_front #(
    .MAX_LINE_PAIRS (MAX_LINE_PAIRS),
    .QUEUE_DEPTH    (QDEPTH)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .full           (full),
    .item           (item),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_line_pairs (cfg_line_pairs),
    .q_push         (q_push),
    .q_item         (q_item),
    .q_count        (q_count)
  );

  // back: result queue
  bnnd_queue #(
    .QUEUE_DEPTH (QDEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .q_push  (q_push),
    .q_item  (q_item),
    .q_count (q_count),
    .pop     (pop),
    .empty   (empty),
    .result  (result)
  );

endmodule

`default_nettype wire

@@ hw/rtl/bnnd_checker.sv @@
// ----------------------------------------------------------------------------
// bnnd_checker
// Port-level checks of the demosaic core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "bayer_nearest_neighbour_demosaic_core_assert.svh"

module bnnd_checker (
  input wire logic                              clk,
  input wire logic                              rst,
  input wire logic                              push,
  input wire logic                              full,
  input wire logic                              empty,
  input wire logic                              pop,
  input wire bnnd_pkg::out_item_t               result
);

  // reset leaves nothing queued and room for input
  `BNND_ASSERT_RST(a_reset_clear, clk, rst |=> (empty && !full), "not clear after reset")

  // a waiting result holds until taken
  `BNND_ASSERT(a_result_hold, clk, rst, (!empty && !pop) |=> (!empty && $stable(result)), "stalled result changed")

  // an empty queue always leaves room, since only one item can be in flight
  `BNND_ASSERT(a_room_when_empty, clk, rst, empty |-> !full, "full while empty")

  // a result only appears in the queue after an item has been accepted
  `BNND_ASSERT(a_no_spurious, clk, rst, (!(push && !full) ##1 empty) |=> empty, "result without item")

endmodule

bind bayer_nearest_neighbour_demosaic_core bnnd_checker u_bnnd_checker (
  .clk            (clk),
  .rst            (rst),
  .push           (push),
  .full           (full),
  .empty          (empty),
  .pop            (pop),
  .result         (result)
);

`default_nettype wire

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// Testbench for bayer_nearest_neighbour_demosaic_core
// Drives packed RGGB pixel pairs and row-length writes into the core. An
// in-bench model of the line store and row position predicts every quad.
// Each popped quad is compared field by field with the oldest expected quad.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

  localparam int MAX_PAIRS    = bnnd_pkg::MAX_LINE_PAIRS_DEF;
  localparam int SETTLE_CYCLES = 8;
  localparam int STALL_LIMIT  = 2000;
  localparam int N_RANDOM     = 380;

  // Directed plan: an item, or a write of the row length
  typedef enum logic {PLAN_ITEM, PLAN_CFG} plan_op_t;

  typedef struct packed {
    plan_op_t              op;
    bnnd_pkg::in_item_t    pair;
    logic [11:0]           pairs;
    logic                  typed;
    bnnd_pkg::out_item_t   quad;
  } plan_row_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                push = 1'b0;
  logic                full;
  bnnd_pkg::in_item_t  item = '0;
  logic                empty;
  logic                pop = 1'b0;
  bnnd_pkg::out_item_t result;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [11:0]         cfg_line_pairs = '0;

  // Model state: stored even-row pairs and row position
  logic [15:0] row_store [MAX_PAIRS];
  int          pred_col = 0;
  bit          pred_odd = 1'b0;
  logic [11:0] pred_pairs = bnnd_pkg::LINE_PAIRS_RESET;

  bnnd_pkg::out_item_t quad_expect [$];
  int          mismatches = 0;
  int          stall_cycles = 0;
  bit          no_idle = 1'b0;

  plan_row_t plan [24] = '{
    '{PLAN_ITEM, 24'h000000, 12'd0, 1'b0, '0},
    '{PLAN_ITEM, 24'hFFFFFF, 12'd0, 1'b0, '0},
    '{PLAN_ITEM, 24'hA53C96, 12'd0, 1'b0, '0},
    '{PLAN_ITEM, 24'h5AC369, 12'd0, 1'b0, '0},
    // shrink mid-row: the next item ends the even row
    '{PLAN_CFG,  24'h000000, 12'd3, 1'b0, '0},
    '{PLAN_ITEM, 24'h123456, 12'd0, 1'b0, '0},
    '{PLAN_ITEM, 24'h11F00F, 12'd0, 1'b1, '{8'h00, 8'h00, 8'h11, 8'h00, 11'd0, 1'b0}},
    '{PLAN_ITEM, 24'hEE0FF0, 12'd0, 1'b1, '{8'hFF, 8'hFF, 8'hEE, 8'hFF, 11'd1, 1'b0}},
    '{PLAN_ITEM, 24'h00A05F, 12'd0, 1'b0, '0},
    // zero length behaves as one pair
    '{PLAN_CFG,  24'h000000, 12'd0, 1'b0, '0},
    '{PLAN_ITEM, 24'h800880, 12'd0, 1'b0, '0},
    '{PLAN_ITEM, 24'h7FF77F, 12'd0, 1'b1, '{8'h80, 8'h88, 8'h7F, 8'h77, 11'd0, 1'b1}},
    // oversize length clamps to the store depth
    '{PLAN_CFG,  24'h000000, 12'd4095, 1'b0, '0},
    '{PLAN_ITEM, 24'h010203, 12'd0, 1'b0, '0},
    '{PLAN_ITEM, 24'hFEFDFC, 12'd0, 1'b0, '0},
    // shrink below the current column on an even row
    '{PLAN_CFG,  24'h000000, 12'd2, 1'b0, '0},
    '{PLAN_ITEM, 24'h334455, 12'd0, 1'b0, '0},
    '{PLAN_ITEM, 24'h102030, 12'd0, 1'b0, '0},
    '{PLAN_ITEM, 24'hC00CC0, 12'd0, 1'b0, '0},
    '{PLAN_ITEM, 24'hAA55AA, 12'd0, 1'b0, '0},
    '{PLAN_ITEM, 24'h55AA55, 12'd0, 1'b0, '0},
    '{PLAN_ITEM, 24'h010101, 12'd0, 1'b0, '0},
    // shrink mid-row on an odd row
    '{PLAN_CFG,  24'h000000, 12'd1, 1'b0, '0},
    '{PLAN_ITEM, 24'h020202, 12'd0, 1'b0, '0}
  };

  bayer_nearest_neighbour_demosaic_core dut (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .full           (full),
    .item           (item),
    .empty          (empty),
    .pop            (pop),
    .result         (result),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_line_pairs (cfg_line_pairs)
  );

  always #10 clk = ~clk;

  // Row length in use: zero acts as one, oversize clamps
  function automatic int eff_pairs(input logic [11:0] n);
    if (n == 12'd0) return 1;
    if (int'(n) > MAX_PAIRS) return MAX_PAIRS;
    return int'(n);
  endfunction

  // Advance the model by one pair; odd rows yield a quad
  function automatic void predict_quad(input bnnd_pkg::in_item_t x, output bit got,
                                       output bnnd_pkg::out_item_t q);
    logic [7:0] second;
    bit         last;
    second = {x.byte_b[3:0], x.byte_c[7:4]};
    last = (pred_col + 1 >= eff_pairs(pred_pairs));
    got = pred_odd;
    q = '0;
    if (!pred_odd) begin
      row_store[pred_col] = {x.byte_a, second};
    end else begin
      q.red         = row_store[pred_col][15:8];
      q.green_upper = row_store[pred_col][7:0];
      q.green_lower = x.byte_a;
      q.blue        = second;
      q.quad_column = pred_col[10:0];
      q.row_end     = last;
    end
    if (last) begin
      pred_col = 0;
      pred_odd = !pred_odd;
    end else begin
      pred_col = pred_col + 1;
    end
  endfunction

  // Offer one pair, with random sender gaps, and record its quad
  task automatic send_pair(input bnnd_pkg::in_item_t x, input bit typed,
                           input bnnd_pkg::out_item_t typed_quad);
    bnnd_pkg::out_item_t q;
    bit                  got;
    if (!no_idle && $urandom_range(99) < 19) begin
      push <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 19);
    end
    item <= x;
    push <= 1'b1;
    do @(posedge clk); while (full);
    predict_quad(x, got, q);
    if (got) quad_expect.push_back(typed ? typed_quad : q);
  endtask

  // Hold off items until every quad is out and the pipe is quiet
  task automatic drain_quads();
    push <= 1'b0;
    while (quad_expect.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Row length write, only once the core is idle
  task automatic write_line_pairs(input logic [11:0] v);
    drain_quads();
    cfg_line_pairs <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    pred_pairs = v;
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
    end
  endtask

  // Result side: random pop, compare each popped quad
  always @(posedge clk) begin
    bnnd_pkg::out_item_t want;
    if (!rst && pop && !empty) begin
      if (quad_expect.size() == 0) begin
        mismatches++;
        $display("%0t: quad expected none actual %h", $time, result);
      end else begin
        want = quad_expect.pop_front();
        check_field("red", 32'(want.red), 32'(result.red));
        check_field("green_upper", 32'(want.green_upper), 32'(result.green_upper));
        check_field("green_lower", 32'(want.green_lower), 32'(result.green_lower));
        check_field("blue", 32'(want.blue), 32'(result.blue));
        check_field("quad_column", 32'(want.quad_column), 32'(result.quad_column));
        check_field("row_end", 32'(want.row_end), 32'(result.row_end));
      end
    end
    if (rst) pop <= 1'b0;
    else pop <= no_idle || ($urandom_range(99) >= 19);
  end

  // Watchdog on cycles with no handshake at all
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("bayer_nearest_neighbour_demosaic_core: mismatch");
        $finish;
      end
    end
  end

  initial begin
    logic [31:0] rnd;
    logic [11:0] len;
    int          r;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed plan
    foreach (plan[i]) begin
      if (plan[i].op == PLAN_CFG) write_line_pairs(plan[i].pairs);
      else send_pair(plan[i].pair, plan[i].typed, plan[i].quad);
    end

    // Random pairs with occasional length changes and drains
    for (int i = 0; i < N_RANDOM; i++) begin
      no_idle = (i >= 150 && i < 260);
      if (i == 300 || $urandom_range(99) == 0) drain_quads();
      if ($urandom_range(99) < 4) begin
        r = $urandom_range(99);
        if (r < 5) len = 12'd0;
        else if (r < 10) len = 12'd4095;
        else if (r < 14) len = 12'd2048;
        else if (r < 22) len = 12'($urandom_range(64, 17));
        else len = 12'($urandom_range(16, 1));
        // odd rows may only shrink: longer rows would read unstored pairs
        if (!pred_odd || eff_pairs(len) <= eff_pairs(pred_pairs)) write_line_pairs(len);
      end
      rnd = $urandom;
      send_pair(rnd[23:0], 1'b0, '0);
    end
    no_idle = 1'b0;

    drain_quads();
    if (mismatches == 0 && quad_expect.size() == 0) begin
      $display("bayer_nearest_neighbour_demosaic_core: match");
    end else begin
      $display("bayer_nearest_neighbour_demosaic_core: mismatch");
    end
    $finish;
  end

endmodule
